### rtl/core/rcpw_pkg.sv
// Package for the four-channel RC pulse width capture block.
// Holds the transaction payload structs, register indexes and reset values.
// No dependencies.
package rcpw_pkg;

  // Number of receiver channels and width of a reported pulse width
  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned GAP_W    = 8;
  localparam int unsigned MIN_W    = 12;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_TICKS = 2'd1;

  // Register reset values
  localparam logic [GAP_W-1:0] GAP_TICKS_RST       = 8'd10;
  localparam logic [MIN_W-1:0] MIN_PULSE_TICKS_RST = 12'd20;

  // Frame status codes
  localparam logic STATUS_VALID   = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // One sampled tick of the four channel lines
  typedef struct packed {
    logic line_one;
    logic line_two;
    logic line_three;
    logic line_four;
  } in_item_t;

  // One captured frame
  typedef struct packed {
    logic               frame_status;
    logic [WIDTH_W-1:0] width_one;
    logic [WIDTH_W-1:0] width_two;
    logic [WIDTH_W-1:0] width_three;
    logic [WIDTH_W-1:0] width_four;
  } out_item_t;

endpackage

### rtl/core/rc_channel_pulse_width_capture_top.sv
// Top level of the four-channel RC pulse width capture block.
// Depends on rcpw_pkg for payload structs, register indexes and reset values.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one sampled tick of
//   the four receiver lines per transaction. The lowest numbered high line
//   has its high-tick count raised (saturating at 2^COUNT_WIDTH - 1). A run
//   of gap_ticks low ticks ends the frame and produces one transaction on
//   the result channel (out_valid, out_stall, out_data): the four widths and
//   a status that is invalid when any count is not above min_pulse_ticks.
//   The block then waits in a gap until the next high tick, which clears the
//   counts and starts a new frame.
//   Throughput is one tick per cycle while in_stall is low. The counters and
//   the frame-end compare feed the output queue: the ending tick's result is
//   registered in the result register, or in the skid register behind a held one.
//   A two-entry output queue (result register plus skid register) lets ticks
//   keep flowing while a result waits under out_stall; in_stall rises only
//   when both entries hold a result.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
//   ready and takes effect from the next tick; unknown indexes are dropped.
//   Synchronous active-low reset clears counts, low run, gap state and the
//   output queue, and loads gap_ticks = 10 and min_pulse_ticks = 20.
module rc_channel_pulse_width_capture_top #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Tick input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rcpw_pkg::in_item_t                  in_data,
  // Frame results
  output logic                                out_valid,
  input  logic                                out_stall,
  output rcpw_pkg::out_item_t                 out_data,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned NCH   = rcpw_pkg::NUM_CH;
  localparam int unsigned CMP_W = (COUNT_WIDTH > rcpw_pkg::WIDTH_W) ?
                                  COUNT_WIDTH : rcpw_pkg::WIDTH_W;

  // Configuration registers
  logic [rcpw_pkg::GAP_W-1:0] gap_ticks_r;
  logic [rcpw_pkg::MIN_W-1:0] min_pulse_r;

  // Frame state
  logic                       in_gap_r,  in_gap_nxt;
  logic [rcpw_pkg::GAP_W-1:0] low_run_r, low_run_nxt;
  logic [COUNT_WIDTH-1:0]     cnt_r   [NCH];
  logic [COUNT_WIDTH-1:0]     cnt_nxt [NCH];

  // Output queue
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  rcpw_pkg::out_item_t out_data_r, out_data_nxt;
  rcpw_pkg::out_item_t skid_data_r, skid_data_nxt;

  logic                accept;
  logic [NCH-1:0]      lines;
  logic [NCH-1:0]      sel;
  logic                lower_high;
  logic                any_high;
  logic [rcpw_pkg::GAP_W-1:0] low_run_inc;
  logic                fire;
  logic                too_short;
  logic [CMP_W-1:0]    cnt_ext [NCH];
  logic [CMP_W-1:0]    min_ext;
  rcpw_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r <= rcpw_pkg::GAP_TICKS_RST;
      min_pulse_r <= rcpw_pkg::MIN_PULSE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcpw_pkg::REG_GAP_TICKS:       gap_ticks_r <= cfg_data[rcpw_pkg::GAP_W-1:0];
        rcpw_pkg::REG_MIN_PULSE_TICKS: min_pulse_r <= cfg_data[rcpw_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Prioritize the lowest numbered high line
  assign lines    = {in_data.line_four, in_data.line_three,
                     in_data.line_two, in_data.line_one};
  assign any_high = |lines;
  always_comb begin
    lower_high = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      sel[i]     = lines[i] && !lower_high;
      lower_high = lower_high || lines[i];
    end
  end

  // Saturate the low run at its maximum
  assign low_run_inc = (low_run_r == '1) ? low_run_r
                                         : low_run_r + rcpw_pkg::GAP_W'(1);

  // Frame-end compare and status
  assign min_ext = CMP_W'(min_pulse_r);
  always_comb begin
    too_short = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      cnt_ext[i] = CMP_W'(cnt_r[i]);
      if (cnt_ext[i] <= min_ext) too_short = 1'b1;
    end
  end

  assign fire = accept && !in_gap_r && !any_high && (low_run_inc >= gap_ticks_r);

  always_comb begin
    res.frame_status = too_short ? rcpw_pkg::STATUS_INVALID : rcpw_pkg::STATUS_VALID;
    res.width_one    = cnt_ext[0][rcpw_pkg::WIDTH_W-1:0];
    res.width_two    = cnt_ext[1][rcpw_pkg::WIDTH_W-1:0];
    res.width_three  = cnt_ext[2][rcpw_pkg::WIDTH_W-1:0];
    res.width_four   = cnt_ext[3][rcpw_pkg::WIDTH_W-1:0];
  end

  // Advance counts, low run and gap state for an accepted tick
  always_comb begin
    in_gap_nxt  = in_gap_r;
    low_run_nxt = low_run_r;
    for (int i = 0; i < NCH; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (accept) begin
      if (in_gap_r) begin
        if (any_high) begin
          // New frame: clear counts and count this tick
          in_gap_nxt  = 1'b0;
          low_run_nxt = '0;
          for (int i = 0; i < NCH; i++) begin
            cnt_nxt[i] = sel[i] ? COUNT_WIDTH'(1) : '0;
          end
        end
      end else if (any_high) begin
        low_run_nxt = '0;
        for (int i = 0; i < NCH; i++) begin
          if (sel[i] && (cnt_r[i] != '1)) cnt_nxt[i] = cnt_r[i] + COUNT_WIDTH'(1);
        end
      end else begin
        low_run_nxt = low_run_inc;
        if (low_run_inc >= gap_ticks_r) in_gap_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_gap_r  <= 1'b0;
      low_run_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      in_gap_r  <= in_gap_nxt;
      low_run_r <= low_run_nxt;
      for (int i = 0; i < NCH; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Output queue: result register backed by one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = fire;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = fire;
        out_data_nxt  = res;
      end
    end else if (fire) begin
      // Hold the stalled result, park the new one
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
